@@ rtl/core/odd_even_transposition_sorter_assert.svh @@
// assertion macros for the odd-even transposition sorter
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_ASSERT_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_ASSERT_SVH

`ifndef SYNTHESIS

// property holds in every cycle out of reset
`define OETS_ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("oets assertion failed");

// consequent holds in the same cycle as the antecedent
`define OETS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("oets assertion failed");

// consequent holds in the cycle after the antecedent
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("oets assertion failed");

`else

`define OETS_ASSERT_ALWAYS(label, clk, rst_n, prop)
`define OETS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/core/oets_pkg.sv @@
`timescale 1ns / 1ps

package oets_pkg;

  // capacity of the cell row
  localparam int MaxElements = 64;
  localparam int CountW      = $clog2(MaxElements + 1);
  localparam int ValueW      = 32;

  typedef logic signed [ValueW-1:0] value_t;

  // what every cell does in one cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_SORT,
    CELL_EMIT
  } cell_op_e;

  // control handed from the sequencer to one cell
  typedef struct packed {
    cell_op_e op;
    logic     lower;
    logic     upper;
  } cell_ctrl_t;

endpackage

@@ rtl/core/oets_if.sv @@
`timescale 1ns / 1ps

// input channel: one element per item
interface oets_in_if;
  logic            valid;
  logic            ready;
  oets_pkg::value_t value;
  logic            last;

  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

// output channel: one sorted element per item
interface oets_out_if;
  logic             valid;
  logic             ready;
  oets_pkg::value_t sorted_value;
  logic             final_res;
  logic             overflow;

  modport source (output valid, output sorted_value, output final_res, output overflow,
                  input ready);
  modport sink (input valid, input sorted_value, input final_res, input overflow,
                output ready);
endinterface

@@ rtl/core/odd_even_transposition_sorter.sv @@
`timescale 1ns / 1ps
// Odd-even transposition sorter. Signed 32-bit elements come in one per item
// and shift into a row of 64 cells; the item with last set closes the set.
// The row then runs one compare-exchange phase per cycle, alternating odd
// and even neighbor pairs, for n phases where n is the number of stored
// elements. The elements then shift out of cell 0 smallest first, one per
// cycle while the sink is ready, with final_res on the last. No input is
// taken while a set is sorted or emitted. Elements beyond 64 are dropped
// and overflow is raised on every result of that set.
`include "odd_even_transposition_sorter_assert.svh"

module odd_even_transposition_sorter (
  input  logic      clk_i,
  input  logic      rst_ni,
  oets_in_if.sink   in_i,
  oets_out_if.source out_o
);
  import oets_pkg::*;

  localparam logic [1:0] ST_LOAD = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [CountW-1:0] CountMax = CountW'(MaxElements);

  logic [1:0]        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] step_q, step_d;
  logic              dropped_q, dropped_d;

  logic              in_acc;
  logic              out_acc;
  logic              full;
  logic              step_last;
  logic              pair_par;
  cell_op_e          op;

  value_t     value_w [MaxElements];
  cell_ctrl_t ctrl_w  [MaxElements];

  assign in_acc    = in_i.valid && in_i.ready;
  assign out_acc   = out_o.valid && out_o.ready;
  assign full      = (count_q == CountMax);
  assign step_last = (step_q == (count_q - CountW'(1)));
  // phase 0 pairs start at cell 1, phase 1 at cell 0
  assign pair_par  = ~step_q[0];

  // row operation for this cycle
  always_comb begin
    op = CELL_HOLD;
    case (state_q)
      ST_LOAD: if (in_acc && !full) op = CELL_LOAD;
      ST_SORT: op = CELL_SORT;
      ST_EMIT: if (out_acc) op = CELL_EMIT;
      default: op = CELL_HOLD;
    endcase
  end

  // cell row with neighbor links
  for (genvar i = 0; i < MaxElements; i++) begin : g_cell
    localparam logic [CountW-1:0] IdxP1 = CountW'(i + 1);
    localparam logic [CountW-1:0] Idx   = CountW'(i);
    localparam logic              Par   = 1'(i % 2);
    value_t left_w;
    value_t right_w;

    if (i == 0) begin : g_first
      assign left_w = in_i.value;
    end else begin : g_mid_left
      assign left_w = value_w[i-1];
    end

    if (i == MaxElements - 1) begin : g_lastc
      assign right_w = value_w[i];
    end else begin : g_mid_right
      assign right_w = value_w[i+1];
    end

    assign ctrl_w[i].op    = op;
    assign ctrl_w[i].lower = (Par == pair_par) && (IdxP1 < count_q);
    assign ctrl_w[i].upper = (i != 0) && (Par != pair_par) && (Idx < count_q);

    oets_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_w[i]),
      .left_i  (left_w),
      .right_i (right_w),
      .value_o (value_w[i])
    );
  end

  // sequencer: load, sort phases, emit
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    step_d    = step_q;
    dropped_d = dropped_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            count_d = count_q + CountW'(1);
          end
          if (in_i.last) begin
            state_d = ST_SORT;
            step_d  = '0;
          end
        end
      end
      ST_SORT: begin
        if (step_last) begin
          state_d = ST_EMIT;
          step_d  = '0;
        end else begin
          step_d = step_q + CountW'(1);
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (step_last) begin
            state_d   = ST_LOAD;
            count_d   = '0;
            dropped_d = 1'b0;
            step_d    = '0;
          end else begin
            step_d = step_q + CountW'(1);
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_LOAD;
      count_q   <= '0;
      step_q    <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      dropped_q <= dropped_d;
    end
  end

  // handshake and result fields
  assign in_i.ready         = (state_q == ST_LOAD);
  assign out_o.valid        = (state_q == ST_EMIT);
  assign out_o.sorted_value = value_w[0];
  assign out_o.final_res    = step_last;
  assign out_o.overflow     = dropped_q;

  `OETS_ASSERT_ALWAYS(a_count_cap, clk_i, rst_ni, count_q <= CountMax)
  `OETS_ASSERT_IMPL(a_sort_nonempty, clk_i, rst_ni, state_q == ST_SORT,
                    (count_q != '0) && (step_q < count_q))
  `OETS_ASSERT_IMPL(a_emit_range, clk_i, rst_ni, out_o.valid, step_q < count_q)
  `OETS_ASSERT_NEXT(a_last_sorts, clk_i, rst_ni, in_acc && in_i.last,
                    (state_q == ST_SORT) && (step_q == '0))
  `OETS_ASSERT_NEXT(a_set_done, clk_i, rst_ni, out_acc && out_o.final_res,
                    (state_q == ST_LOAD) && (count_q == '0) && !dropped_q)

endmodule

@@ rtl/core/oets_cell.sv @@
`timescale 1ns / 1ps

module oets_cell (
  input  logic                clk_i,
  input  oets_pkg::cell_ctrl_t ctrl_i,
  input  oets_pkg::value_t    left_i,
  input  oets_pkg::value_t    right_i,
  output oets_pkg::value_t    value_o
);
  import oets_pkg::*;

  value_t value_q;
  value_t value_d;

  // shift in, compare-exchange with the partner, or shift out
  always_comb begin
    value_d = value_q;
    case (ctrl_i.op)
      CELL_LOAD: value_d = left_i;
      CELL_EMIT: value_d = right_i;
      CELL_SORT: begin
        if (ctrl_i.lower && (right_i < value_q)) begin
          value_d = right_i;
        end else if (ctrl_i.upper && (left_i > value_q)) begin
          value_d = left_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // element register
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule
